>>> hw/rtl/dcsd_pkg.sv
package dcsd_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [15:0] NEAR_RST   = 16'd500;
  localparam logic [15:0] FAR_RST    = 16'd1000;
  localparam logic [11:0] SWIPE_RST  = 12'd75;
  localparam logic [11:0] MARGIN_RST = 12'd50;
  localparam logic [23:0] MINPT_RST  = 24'd400;
  localparam logic [12:0] WIDTH_RST  = 13'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  typedef enum logic [2:0] {
    REG_NEAR_LIMIT,
    REG_FAR_LIMIT,
    REG_SWIPE_DISTANCE,
    REG_DIRECTION_MARGIN,
    REG_MIN_POINTS,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_DIVIDE,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [15:0] near_limit;
    logic [15:0] far_limit;
    logic [11:0] swipe_distance;
    logic [11:0] direction_margin;
    logic [23:0] min_points;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic pix_accept;
    logic div_load;
    logic div_step;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic pix_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/dcsd_in_if.sv
interface dcsd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] depth_sample;

  modport source (output valid, output depth_sample, input ready);
  modport sink (input valid, input depth_sample, output ready);
endinterface

>>> hw/rtl/dcsd_out_if.sv
interface dcsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  swipe;
  logic [15:0] centroid_col;
  logic [1:0]  new_direction;

  modport source (output valid, output swipe, output centroid_col, output new_direction,
                  input ready);
  modport sink (input valid, input swipe, input centroid_col, input new_direction,
                output ready);
endinterface

>>> hw/rtl/dcsd_regs.sv
module dcsd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcsd_pkg::CFG_AW-1:0] paddr,
  input  logic [dcsd_pkg::CFG_DW-1:0] pwdata,
  output logic [dcsd_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output dcsd_pkg::cfg_t              cfg
);
  import dcsd_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_NEAR_LIMIT:       cfg_nxt.near_limit       = pwdata[15:0];
        REG_FAR_LIMIT:        cfg_nxt.far_limit        = pwdata[15:0];
        REG_SWIPE_DISTANCE:   cfg_nxt.swipe_distance   = pwdata[11:0];
        REG_DIRECTION_MARGIN: cfg_nxt.direction_margin = pwdata[11:0];
        REG_MIN_POINTS:       cfg_nxt.min_points       = pwdata[23:0];
        REG_FRAME_WIDTH:      cfg_nxt.frame_width      = pwdata[12:0];
        REG_FRAME_HEIGHT:     cfg_nxt.frame_height     = pwdata[12:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NEAR_LIMIT:       prdata = CFG_DW'(cfg_r.near_limit);
      REG_FAR_LIMIT:        prdata = CFG_DW'(cfg_r.far_limit);
      REG_SWIPE_DISTANCE:   prdata = CFG_DW'(cfg_r.swipe_distance);
      REG_DIRECTION_MARGIN: prdata = CFG_DW'(cfg_r.direction_margin);
      REG_MIN_POINTS:       prdata = CFG_DW'(cfg_r.min_points);
      REG_FRAME_WIDTH:      prdata = CFG_DW'(cfg_r.frame_width);
      REG_FRAME_HEIGHT:     prdata = CFG_DW'(cfg_r.frame_height);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_limit       <= NEAR_RST;
      cfg_r.far_limit        <= FAR_RST;
      cfg_r.swipe_distance   <= SWIPE_RST;
      cfg_r.direction_margin <= MARGIN_RST;
      cfg_r.min_points       <= MINPT_RST;
      cfg_r.frame_width      <= WIDTH_RST;
      cfg_r.frame_height     <= HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hw/rtl/dcsd_ctrl.sv
module dcsd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dcsd_pkg::status_t status,
  output dcsd_pkg::cmd_t    cmd
);
  import dcsd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACCUM: begin
        if (in_valid && status.pix_last) state_nxt = ST_LOAD;
      end
      ST_LOAD:   state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (status.div_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.out_free) state_nxt = ST_ACCUM;
      end
      default:   state_nxt = ST_ACCUM;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_ACCUM: begin
        in_ready       = 1'b1;
        cmd.pix_accept = in_valid;
      end
      ST_LOAD:   cmd.div_load = 1'b1;
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_DECIDE: cmd.decide   = status.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/dcsd_dp.sv
module dcsd_dp #(
  parameter int COORD_BITS = dcsd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dcsd_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dcsd_pkg::cfg_t    cfg,
  input  dcsd_pkg::cmd_t    cmd,
  output dcsd_pkg::status_t status,
  input  logic [15:0]       in_depth,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_swipe,
  output logic [15:0]       out_centroid,
  output logic [1:0]        out_dir
);
  import dcsd_pkg::*;

  localparam int QW   = COORD_BITS + FRAC_BITS;
  localparam int SW   = 3 * COORD_BITS;
  localparam int NW   = 2 * COORD_BITS;
  localparam int LW   = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
  localparam int M1   = (QW > 16) ? QW : 16;
  localparam int M2   = (M1 > 12 + FRAC_BITS) ? M1 : 12 + FRAC_BITS;
  localparam int DW   = M2 + 1;
  localparam int MW   = (NW > 24) ? NW : 24;
  localparam int CNTW = $clog2(QW + 1);
  localparam logic [LW-1:0] SIZE_MAX = LW'(1) << COORD_BITS;

  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] row_r;
  logic [SW-1:0]         sum_r;
  logic [NW-1:0]         count_r;
  logic [15:0]           last_cent_r;
  dir_t                  last_dir_r;
  logic [NW-1:0]         rem_r;
  logic [QW-1:0]         quo_r;
  logic [CNTW-1:0]       div_cnt_r;
  logic                  out_valid_r;
  dir_t                  out_swipe_r;
  logic [15:0]           out_cent_r;
  dir_t                  out_dir_r;

  logic [LW-1:0]         fw;
  logic [LW-1:0]         fh;
  logic [LW-1:0]         w;
  logic [LW-1:0]         h;
  logic [LW-1:0]         col_inc;
  logic [LW-1:0]         row_inc;
  logic                  col_end;
  logic                  row_end;
  logic                  hit;
  logic [NW:0]           part;
  logic [NW:0]           trial;
  logic                  ge;
  logic                  cent_ok;
  logic [QW-1:0]         cent;
  logic signed [DW-1:0]  diff;
  logic signed [DW-1:0]  mag;
  logic signed [DW-1:0]  margin;
  logic signed [DW-1:0]  thresh;
  logic                  big;
  logic                  upd;
  dir_t                  dir;
  dir_t                  swipe;

  assign fw = LW'(cfg.frame_width);
  assign fh = LW'(cfg.frame_height);
  assign w  = (fw == '0) ? LW'(1) : ((fw > SIZE_MAX) ? SIZE_MAX : fw);
  assign h  = (fh == '0) ? LW'(1) : ((fh > SIZE_MAX) ? SIZE_MAX : fh);

  assign col_inc = LW'(col_r) + LW'(1);
  assign row_inc = LW'(row_r) + LW'(1);
  assign col_end = !(col_inc < w);
  assign row_end = !(row_inc < h);

  assign hit = (in_depth != 16'd0) && (in_depth >= cfg.near_limit) &&
               (in_depth <= cfg.far_limit);

  assign part  = {rem_r, quo_r[QW-1]};
  assign ge    = part >= (NW + 1)'(count_r);
  assign trial = part - (NW + 1)'(count_r);

  assign cent_ok = MW'(count_r) > MW'(cfg.min_points);
  assign cent    = cent_ok ? quo_r : '0;
  assign diff    = signed'(DW'(cent)) - signed'(DW'(last_cent_r));
  assign mag     = (diff < 0) ? -diff : diff;
  assign margin  = signed'(DW'(cfg.direction_margin) << FRAC_BITS);
  assign thresh  = signed'(DW'(cfg.swipe_distance) << FRAC_BITS);
  assign big     = mag > thresh;

  always_comb begin
    if (!cent_ok) begin
      dir = DIR_NONE;
    end else if (diff > margin) begin
      dir = DIR_RIGHT;
    end else if (diff < -margin) begin
      dir = DIR_LEFT;
    end else begin
      dir = last_dir_r;
    end
  end

  assign upd   = (dir != last_dir_r) || big;
  assign swipe = big ? last_dir_r : DIR_NONE;

  assign status.pix_last = col_end && row_end;
  assign status.div_last = (div_cnt_r == '0);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_swipe    = out_swipe_r;
  assign out_centroid = out_cent_r;
  assign out_dir      = out_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      last_cent_r <= '0;
      last_dir_r  <= DIR_NONE;
    end else if (cmd.pix_accept) begin
      if (hit) begin
        sum_r <= sum_r + SW'(col_r);
        if (count_r != '1) count_r <= count_r + NW'(1);
      end
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_inc[COORD_BITS-1:0];
      end else begin
        col_r <= col_inc[COORD_BITS-1:0];
      end
    end else if (cmd.decide) begin
      sum_r   <= '0;
      count_r <= '0;
      if (upd) begin
        last_cent_r <= 16'(cent);
        last_dir_r  <= dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r     <= sum_r[SW-1:COORD_BITS];
      quo_r     <= QW'(sum_r[COORD_BITS-1:0]) << FRAC_BITS;
      div_cnt_r <= CNTW'(QW - 1);
    end else if (cmd.div_step) begin
      rem_r     <= ge ? trial[NW-1:0] : part[NW-1:0];
      quo_r     <= {quo_r[QW-2:0], ge};
      div_cnt_r <= div_cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.decide) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_swipe_r <= swipe;
      out_cent_r  <= 16'(cent);
      out_dir_r   <= dir;
    end
  end

endmodule

>>> hw/rtl/depth_centroid_swipe_detector_unit.sv
// Takes one depth word per cycle while collecting a frame.
// After the last pixel of a frame the input stalls while the one-bit-per-cycle restoring
// divider runs and until any earlier result word is taken; then the result word appears
// in the output register; the next frame's pixels are taken while it waits.
// Reset is synchronous and active low; it restores register defaults and clears the pixel
// counters, sums, the stored centroid and direction, and the output valid flag.
module depth_centroid_swipe_detector_unit #(
  parameter int COORD_BITS = dcsd_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dcsd_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dcsd_in_if.sink                     in_ch,
  dcsd_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dcsd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [dcsd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [dcsd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import dcsd_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  dcsd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dcsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dcsd_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .in_depth     (in_ch.depth_sample),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_swipe    (out_ch.swipe),
    .out_centroid (out_ch.centroid_col),
    .out_dir      (out_ch.new_direction)
  );

endmodule

>>> hw/rtl/dcsd_checker.sv
module dcsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_swipe,
  input logic [15:0] out_centroid_col,
  input logic [1:0]  out_new_direction
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_swipe) && $stable(out_centroid_col) && $stable(out_new_direction))
    else $error("stalled output word changed");

  a_new_word_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready) && !$past(in_valid && in_ready))
    else $error("result word appeared without the frame-end stall");

endmodule

bind depth_centroid_swipe_detector_unit dcsd_checker u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_swipe         (out_ch.swipe),
  .out_centroid_col  (out_ch.centroid_col),
  .out_new_direction (out_ch.new_direction)
);
